// File: sv/vipq_pkg.sv
// package with action codes, status codes and shared types for the pending queue
package vipq_pkg;

  typedef enum logic [2:0] {
    ACT_INJECT  = 3'd0,
    ACT_ENABLE  = 3'd1,
    ACT_DISABLE = 3'd2,
    ACT_PEEK    = 3'd3,
    ACT_TAKE    = 3'd4,
    ACT_CLEAR   = 3'd5,
    ACT_SETTYPE = 3'd6,
    ACT_NONE    = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_NOEFF = 2'd1,
    ST_FULL = 2'd2,
    ST_RSVD = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_RD,
    S_EVAL,
    S_SCAN_RD,
    S_SCAN_EV,
    S_CLRQ_RD,
    S_CLRQ_EV,
    S_OUT
  } state_t;

  localparam int ID_W = 10;
  localparam int CNT_W = 5;

  // bitmap word: pending, enabled, fiq type
  typedef struct packed {
    logic pend;
    logic en;
    logic fiq;
  } flags_t;

endpackage

// File: sv/virtual_interrupt_pending_queue_unit.sv
// Virtual interrupt pending queue for one vCPU. Flags (pending, enabled,
// FIQ type) live in a NUM_INTIDS-entry memory and queued IDs in a
// QUEUE_DEPTH-entry memory, each with one write port and a registered read.
// After reset a clearing pass writes zero to every flag memory entry;
// no request is accepted during it. Inject, enable, disable and set type
// step through accept and flag read, modify/write, and result. Peek and
// take examine queue entries from the head, each by a queue read, a flag
// read and an evaluate step; clear of a pending ID walks the whole queue,
// each entry by a read and an evaluate step. Results hold on out_stall.
module virtual_interrupt_pending_queue_unit #(
  parameter int QUEUE_DEPTH = 16,
  parameter int NUM_INTIDS = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  in_action,
  input  logic [vipq_pkg::ID_W-1:0]   in_intid,
  input  logic                        in_is_fiq,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [vipq_pkg::ID_W-1:0]   out_found_id,
  output logic                        out_found_valid,
  output logic [1:0]                  out_status,
  output logic [vipq_pkg::CNT_W-1:0]  out_irq_pending_count,
  output logic [vipq_pkg::CNT_W-1:0]  out_fiq_pending_count
);

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QFW = $clog2(QUEUE_DEPTH + 1);
  localparam int FAW = $clog2(NUM_INTIDS);
  localparam int IDW = vipq_pkg::ID_W;
  localparam int CW = vipq_pkg::CNT_W;
  localparam int CCW = QFW + 1;

  vipq_pkg::state_t state_r, state_nxt;
  vipq_pkg::action_t act_r, act_nxt;
  logic [IDW-1:0] id_r, id_nxt;
  logic fiq_in_r, fiq_in_nxt;
  logic [QAW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [QFW-1:0] fill_r, fill_nxt, cnt_r, cnt_nxt;
  logic [CCW-1:0] irq_r, irq_nxt, fiq_r, fiq_nxt;
  logic [FAW-1:0] clr_r, clr_nxt;
  logic [IDW-1:0] fid_r, fid_nxt;
  logic fval_r, fval_nxt;
  logic [1:0] st_r, st_nxt;

  logic fwe, qwe;
  logic [FAW-1:0] fwaddr, fraddr;
  vipq_pkg::flags_t fwdata, frdata;
  logic [QAW-1:0] qwaddr, qraddr;
  logic [IDW-1:0] qwdata, qrdata;

  vipq_flag_ram #(.DEPTH(NUM_INTIDS), .AW(FAW)) u_flags (
    .clk(clk), .we(fwe), .waddr(fwaddr), .wdata(fwdata),
    .raddr(fraddr), .rdata(frdata)
  );

  vipq_id_ram #(.DEPTH(QUEUE_DEPTH), .AW(QAW)) u_ids (
    .clk(clk), .we(qwe), .waddr(qwaddr), .wdata(qwdata),
    .raddr(qraddr), .rdata(qrdata)
  );

  function automatic logic [QAW-1:0] nslot(input logic [QAW-1:0] i);
    logic [QAW-1:0] r;
    if ({1'b0, i} + 1'b1 >= (QAW+1)'(QUEUE_DEPTH)) begin
      r = '0;
    end else begin
      r = i + 1'b1;
    end
    return r;
  endfunction

  logic id_ok;
  assign id_ok = ({2'b0, id_r} < 12'(NUM_INTIDS)) || (NUM_INTIDS >= 1024);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vipq_pkg::S_CLR;
      clr_r <= '0;
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
      irq_r <= '0;
      fiq_r <= '0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
      irq_r <= irq_nxt;
      fiq_r <= fiq_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r <= act_nxt;
    id_r <= id_nxt;
    fiq_in_r <= fiq_in_nxt;
    fid_r <= fid_nxt;
    fval_r <= fval_nxt;
    st_r <= st_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    fill_nxt = fill_r;
    irq_nxt = irq_r;
    fiq_nxt = fiq_r;
    cnt_nxt = cnt_r;
    act_nxt = act_r;
    id_nxt = id_r;
    fiq_in_nxt = fiq_in_r;
    fid_nxt = fid_r;
    fval_nxt = fval_r;
    st_nxt = st_r;
    fwe = 1'b0;
    fwaddr = FAW'(id_r);
    fwdata = frdata;
    fraddr = FAW'(id_r);
    qwe = 1'b0;
    qwaddr = tail_r;
    qwdata = id_r;
    qraddr = head_r;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      vipq_pkg::S_CLR: begin
        fwe = 1'b1;
        fwaddr = clr_r;
        fwdata = '0;
        clr_nxt = clr_r + 1'b1;
        if ({1'b0, clr_r} == (FAW+1)'(NUM_INTIDS - 1)) begin
          state_nxt = vipq_pkg::S_IDLE;
        end
      end
      vipq_pkg::S_IDLE: begin
        in_stall = 1'b0;
        fraddr = FAW'(in_intid);
        if (in_valid) begin
          act_nxt = vipq_pkg::action_t'(in_action);
          id_nxt = in_intid;
          fiq_in_nxt = in_is_fiq;
          fid_nxt = '0;
          fval_nxt = 1'b0;
          st_nxt = vipq_pkg::ST_NOEFF;
          state_nxt = vipq_pkg::S_EVAL;
        end
      end
      vipq_pkg::S_EVAL: begin
        case (act_r)
          vipq_pkg::ACT_INJECT: begin
            state_nxt = vipq_pkg::S_OUT;
            if (id_ok && !frdata.pend) begin
              if (fill_r >= QFW'(QUEUE_DEPTH)) begin
                st_nxt = vipq_pkg::ST_FULL;
              end else begin
                qwe = 1'b1;
                tail_nxt = nslot(tail_r);
                fill_nxt = fill_r + 1'b1;
                fwe = 1'b1;
                fwdata.pend = 1'b1;
                if (frdata.en) begin
                  if (frdata.fiq) fiq_nxt = fiq_r + 1'b1;
                  else irq_nxt = irq_r + 1'b1;
                end
                st_nxt = vipq_pkg::ST_DONE;
              end
            end
          end
          vipq_pkg::ACT_ENABLE, vipq_pkg::ACT_DISABLE: begin
            state_nxt = vipq_pkg::S_OUT;
            if (id_ok) begin
              fwe = 1'b1;
              fwdata.en = (act_r == vipq_pkg::ACT_ENABLE);
              if (frdata.pend && frdata.en != fwdata.en) begin
                if (fwdata.en) begin
                  if (frdata.fiq) fiq_nxt = fiq_r + 1'b1;
                  else irq_nxt = irq_r + 1'b1;
                end else begin
                  if (frdata.fiq) begin
                    if (fiq_r != 0) fiq_nxt = fiq_r - 1'b1;
                  end else if (irq_r != 0) irq_nxt = irq_r - 1'b1;
                end
              end
              st_nxt = vipq_pkg::ST_DONE;
            end
          end
          vipq_pkg::ACT_SETTYPE: begin
            state_nxt = vipq_pkg::S_OUT;
            if (id_ok) begin
              fwe = 1'b1;
              fwdata.fiq = fiq_in_r;
              if (frdata.pend && frdata.en && frdata.fiq != fiq_in_r) begin
                if (frdata.fiq) begin
                  if (fiq_r != 0) fiq_nxt = fiq_r - 1'b1;
                  irq_nxt = irq_r + 1'b1;
                end else begin
                  if (irq_r != 0) irq_nxt = irq_r - 1'b1;
                  fiq_nxt = fiq_r + 1'b1;
                end
              end
              st_nxt = vipq_pkg::ST_DONE;
            end
          end
          vipq_pkg::ACT_PEEK, vipq_pkg::ACT_TAKE: begin
            cnt_nxt = '0;
            if ((irq_r == 0 && fiq_r == 0) || fill_r == 0) begin
              state_nxt = vipq_pkg::S_OUT;
            end else begin
              state_nxt = vipq_pkg::S_SCAN_RD;
            end
          end
          vipq_pkg::ACT_CLEAR: begin
            cnt_nxt = fill_r;
            if (id_ok && frdata.pend) begin
              fwe = 1'b1;
              fwdata.pend = 1'b0;
              if (frdata.en) begin
                if (frdata.fiq) begin
                  if (fiq_r != 0) fiq_nxt = fiq_r - 1'b1;
                end else if (irq_r != 0) irq_nxt = irq_r - 1'b1;
              end
              st_nxt = vipq_pkg::ST_DONE;
              state_nxt = (fill_r == 0) ? vipq_pkg::S_OUT : vipq_pkg::S_CLRQ_RD;
            end else begin
              state_nxt = vipq_pkg::S_OUT;
            end
          end
          default: begin
            state_nxt = vipq_pkg::S_OUT;
          end
        endcase
      end
      vipq_pkg::S_SCAN_RD: begin
        // head id read from queue memory this cycle
        qraddr = head_r;
        state_nxt = vipq_pkg::S_RD;
      end
      vipq_pkg::S_RD: begin
        // queue data valid; fetch its flags
        fraddr = FAW'(qrdata);
        id_nxt = qrdata;
        state_nxt = vipq_pkg::S_SCAN_EV;
      end
      vipq_pkg::S_SCAN_EV: begin
        fraddr = FAW'(id_r);
        if (frdata.en && id_ok) begin
          fid_nxt = id_r;
          fval_nxt = 1'b1;
          st_nxt = vipq_pkg::ST_DONE;
          state_nxt = vipq_pkg::S_OUT;
          if (act_r == vipq_pkg::ACT_TAKE) begin
            head_nxt = nslot(head_r);
            fill_nxt = fill_r - 1'b1;
            fwe = 1'b1;
            fwdata.pend = 1'b0;
            if (frdata.fiq) begin
              if (fiq_r != 0) fiq_nxt = fiq_r - 1'b1;
            end else if (irq_r != 0) irq_nxt = irq_r - 1'b1;
          end
        end else begin
          // rotate head entry to tail
          qwe = 1'b1;
          qwaddr = tail_r;
          qwdata = id_r;
          head_nxt = nslot(head_r);
          tail_nxt = nslot(tail_r);
          cnt_nxt = cnt_r + 1'b1;
          state_nxt = (cnt_r + 1'b1 >= fill_r) ? vipq_pkg::S_OUT : vipq_pkg::S_SCAN_RD;
        end
      end
      vipq_pkg::S_CLRQ_RD: begin
        qraddr = head_r;
        state_nxt = vipq_pkg::S_CLRQ_EV;
      end
      vipq_pkg::S_CLRQ_EV: begin
        head_nxt = nslot(head_r);
        if (qrdata != id_r) begin
          qwe = 1'b1;
          qwaddr = tail_r;
          qwdata = qrdata;
          tail_nxt = nslot(tail_r);
        end else begin
          fill_nxt = fill_r - 1'b1;
        end
        cnt_nxt = cnt_r - 1'b1;
        state_nxt = (cnt_r == 1) ? vipq_pkg::S_OUT : vipq_pkg::S_CLRQ_RD;
      end
      vipq_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = vipq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = vipq_pkg::S_IDLE;
      end
    endcase
  end

  assign out_found_id = fid_r;
  assign out_found_valid = fval_r;
  assign out_status = st_r;
  assign out_irq_pending_count = CW'(irq_r);
  assign out_fiq_pending_count = CW'(fiq_r);

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= QFW'(QUEUE_DEPTH)) else $error("fill above depth");
  a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found_valid |-> out_status == vipq_pkg::ST_DONE)
    else $error("found without done status");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("accept while result pending");
  a_take_pops: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == vipq_pkg::S_SCAN_EV && act_r == vipq_pkg::ACT_TAKE && fval_nxt
    |=> fill_r == $past(fill_r) - 1'b1) else $error("take did not pop");

endmodule

// File: sv/vipq_flag_ram.sv
// per-id flag memory with registered read
module vipq_flag_ram #(
  parameter int DEPTH = 1024,
  parameter int AW = 10
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  vipq_pkg::flags_t wdata,
  input  logic [AW-1:0]   raddr,
  output vipq_pkg::flags_t rdata
);

  vipq_pkg::flags_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/vipq_id_ram.sv
// queue entry memory with registered read
module vipq_id_ram #(
  parameter int DEPTH = 16,
  parameter int AW = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [vipq_pkg::ID_W-1:0] wdata,
  input  logic [AW-1:0]            raddr,
  output logic [vipq_pkg::ID_W-1:0] rdata
);

  logic [vipq_pkg::ID_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
